// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int SLOTS  = 256;
    localparam int KEY_W  = 64;
    localparam int LTR_W  = 8;
    localparam int VEC_W  = 32;
    localparam int CFG_W  = 9;

    // request codes
    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_LOOKUP = 3'd1;
    localparam logic [2:0] FN_REMOVE = 3'd2;
    localparam logic [2:0] FN_UPD_CH = 3'd3;
    localparam logic [2:0] FN_UPD_VC = 3'd4;
    localparam logic [2:0] FN_CLEAR  = 3'd5;
    localparam logic [2:0] FN_UNDEF6 = 3'd6;
    localparam logic [2:0] FN_UNDEF7 = 3'd7;

    // result codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOTFND  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADKEY  = 2'd3;

    // slot marks
    localparam logic [1:0] MK_EMPTY = 2'd0;
    localparam logic [1:0] MK_LIVE  = 2'd1;
    localparam logic [1:0] MK_TOMB  = 2'd2;

    typedef struct packed {
        logic [2:0]       func;
        logic [KEY_W-1:0] key_text;
        logic [LTR_W-1:0] letter_in;
        logic [VEC_W-1:0] vec_in0;
        logic [VEC_W-1:0] vec_in1;
        logic [VEC_W-1:0] vec_in2;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       slot_index;
        logic [LTR_W-1:0] letter_out;
        logic [VEC_W-1:0] vec_out0;
        logic [VEC_W-1:0] vec_out1;
        logic [VEC_W-1:0] vec_out2;
        logic [8:0]       live_entries;
    } rsp_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0]       func;
        logic             bad;
        logic [KEY_W-1:0] key;
        logic [31:0]      sum;
        logic [LTR_W-1:0] letter;
        logic [VEC_W-1:0] vec0;
        logic [VEC_W-1:0] vec1;
        logic [VEC_W-1:0] vec2;
    } job_t;

endpackage

// ===== rtl/lpht_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_front
// Accepts requests, canonicalizes the key, forms the hash sum and bad flag.
// ----------------------------------------------------------------------------
module lpht_front #(
    parameter int KEY_BYTES = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  lpht_pkg::req_t in_req,
    output logic          job_valid,
    input  logic          job_ready,
    output lpht_pkg::job_t job
);
    import lpht_pkg::*;

    logic       job_valid_reg;
    job_t       job_reg;
    job_t       job_next;
    logic       ended;
    logic [7:0] ch;
    logic [31:0] sh;

    assign in_ready  = !job_valid_reg || job_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    // key scan over at most eight bytes
    always_comb begin
        job_next        = '0;
        job_next.func   = in_req.func;
        job_next.letter = in_req.letter_in;
        job_next.vec0   = in_req.vec_in0;
        job_next.vec1   = in_req.vec_in1;
        job_next.vec2   = in_req.vec_in2;
        ended = 1'b0;
        ch = '0;
        sh = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            ch = in_req.key_text[8*b +: 8];
            if (ch == 8'd0) ended = 1'b1;
            if (!ended) begin
                if (ch[7]) job_next.bad = 1'b1;
                job_next.key[8*b +: 8] = ch;
                sh = {24'd0, ch} << ch[6:2];
                job_next.sum = job_next.sum + sh;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (in_ready) begin
            job_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== rtl/lpht_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module lpht_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  lpht_pkg::job_t wr_job,
    output logic           rd_valid,
    input  logic           rd_ready,
    output lpht_pkg::job_t rd_job
);
    import lpht_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_en;
    logic       rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // pointers and fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_job;
    end

endmodule

// ===== rtl/lpht_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_back
// Runs one request: modulo reduction, probe walk, store update, result.
// ----------------------------------------------------------------------------
module lpht_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [8:0]     table_size,
    input  logic           job_valid,
    output logic           job_ready,
    input  lpht_pkg::job_t job,
    output logic           out_valid,
    input  logic           out_ready,
    output lpht_pkg::rsp_t out_rsp
);
    import lpht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int NW = AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_SHOW = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;

    // stores
    logic [1:0]       mark_mem [SLOTS];
    logic [KEY_W-1:0] key_mem  [SLOTS];
    logic [LTR_W-1:0] ltr_mem  [SLOTS];
    logic [VEC_W-1:0] v0_mem   [SLOTS];
    logic [VEC_W-1:0] v1_mem   [SLOTS];
    logic [VEC_W-1:0] v2_mem   [SLOTS];

    logic [2:0]       st_reg;
    job_t             job_reg;
    logic [NW-1:0]    n_reg;
    logic [31:0]      rem_reg;
    logic [5:0]       bit_reg;
    logic             neg_reg;
    logic [31:0]      mag_reg;
    logic [AW-1:0]    slot_reg;
    logic [NW-1:0]    step_reg;
    logic [8:0]       live_reg;
    logic [1:0]       mk_rd_reg;
    logic [KEY_W-1:0] key_rd_reg;
    logic [LTR_W-1:0] ltr_rd_reg;
    logic [VEC_W-1:0] v0_rd_reg, v1_rd_reg, v2_rd_reg;
    logic             out_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_out_reg;
    logic [AW-1:0]    clr_reg;

    logic [NW-1:0]    n_eff;
    logic [32:0]      trial;
    logic [NW:0]      slot_inc;
    logic             mk_we;
    logic [1:0]       mk_wd;
    logic [AW-1:0]    mk_wa;
    logic             out_load;

    assign job_ready = (st_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_rsp   = rsp_out_reg;
    assign out_load  = (st_reg == S_OUT) && (!out_valid_reg || out_ready);

    // effective modulus: zero acts as one, clipped to SLOTS
    always_comb begin
        if (table_size == 9'd0) n_eff = NW'(1);
        else if ({23'd0, table_size} > SLOTS) n_eff = NW'(SLOTS);
        else n_eff = NW'(table_size);
    end

    // one restoring division step
    assign trial    = {rem_reg, mag_reg[31]} - {{(33-NW){1'b0}}, n_reg};
    assign slot_inc = {1'b0, slot_reg} + {{(NW-AW){1'b0}}, 1'b1} + 1'b0;

    // mark memory write port
    always_comb begin
        mk_we = 1'b0;
        mk_wd = MK_EMPTY;
        mk_wa = slot_reg;
        if (st_reg == S_CLR) begin
            mk_we = 1'b1;
            mk_wa = clr_reg;
        end else if (st_reg == S_CHK && !job_reg.bad) begin
            if (job_reg.func == FN_INSERT && mk_rd_reg != MK_LIVE) begin
                mk_we = 1'b1;
                mk_wd = MK_LIVE;
            end else if (job_reg.func == FN_REMOVE && mk_rd_reg == MK_LIVE
                         && key_rd_reg == job_reg.key) begin
                mk_we = 1'b1;
                mk_wd = MK_TOMB;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mk_we) mark_mem[mk_wa] <= mk_wd;
        mk_rd_reg <= mark_mem[slot_reg];
    end

    // payload memories: written on insert and updates, read in S_RD for the check in S_CHK
    always_ff @(posedge aclk) begin
        if (st_reg == S_CHK && !job_reg.bad && job_reg.func == FN_INSERT
            && mk_rd_reg != MK_LIVE) begin
            key_mem[slot_reg] <= job_reg.key;
        end
        if (st_reg == S_CHK && !job_reg.bad && mk_rd_reg != MK_LIVE
            && job_reg.func == FN_INSERT) begin
            ltr_mem[slot_reg] <= job_reg.letter;
        end else if (st_reg == S_CHK && !job_reg.bad && mk_rd_reg == MK_LIVE
            && key_rd_reg == job_reg.key && job_reg.func == FN_UPD_CH) begin
            ltr_mem[slot_reg] <= job_reg.letter;
        end
        if (st_reg == S_CHK && !job_reg.bad && ((job_reg.func == FN_INSERT
            && mk_rd_reg != MK_LIVE) || (job_reg.func == FN_UPD_VC
            && mk_rd_reg == MK_LIVE && key_rd_reg == job_reg.key))) begin
            v0_mem[slot_reg] <= job_reg.vec0;
            v1_mem[slot_reg] <= job_reg.vec1;
            v2_mem[slot_reg] <= job_reg.vec2;
        end
        key_rd_reg <= key_mem[slot_reg];
        ltr_rd_reg <= ltr_mem[slot_reg];
        v0_rd_reg  <= v0_mem[slot_reg];
        v1_rd_reg  <= v1_mem[slot_reg];
        v2_rd_reg  <= v2_mem[slot_reg];
    end

    // result register, loaded once the previous result is gone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) rsp_out_reg <= rsp_reg;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= S_CLR;
            clr_reg       <= '0;
            live_reg      <= '0;
        end else begin
            case (st_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(SLOTS - 1)) st_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg  <= job;
                        n_reg    <= n_eff;
                        neg_reg  <= job.sum[31];
                        mag_reg  <= job.sum[31] ? (32'd0 - job.sum) : job.sum;
                        rem_reg  <= '0;
                        bit_reg  <= '0;
                        step_reg <= '0;
                        rsp_reg  <= '0;
                        st_reg   <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (trial[32]) rem_reg <= {rem_reg[30:0], mag_reg[31]};
                    else rem_reg <= trial[31:0];
                    mag_reg <= {mag_reg[30:0], 1'b0};
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 6'd31) begin
                        st_reg <= S_SHOW;
                    end
                end
                S_SHOW: begin
                    // home slot from the residue, then dispatch
                    if (neg_reg && rem_reg != 32'd0)
                        slot_reg <= AW'({{(32-NW){1'b0}}, n_reg} - rem_reg);
                    else
                        slot_reg <= AW'(rem_reg);
                    rsp_reg.live_entries <= (job_reg.func == FN_CLEAR) ? 9'd0 : live_reg;
                    if (job_reg.func == FN_CLEAR) begin
                        live_reg             <= '0;
                        clr_reg              <= '0;
                        st_reg               <= S_OUT;
                    end else if (job_reg.func > FN_CLEAR) begin
                        rsp_reg.status <= ST_NOTFND;
                        st_reg         <= S_OUT;
                    end else if (job_reg.bad) begin
                        rsp_reg.status <= ST_BADKEY;
                        st_reg         <= S_OUT;
                    end else if (job_reg.func == FN_INSERT && live_reg >= n_reg) begin
                        rsp_reg.status <= ST_FULL;
                        st_reg         <= S_OUT;
                    end else begin
                        st_reg <= S_RD;
                    end
                end
                S_RD: begin
                    st_reg <= S_CHK;
                end
                S_CHK: begin
                    if (job_reg.func == FN_INSERT && mk_rd_reg != MK_LIVE) begin
                        live_reg              <= live_reg + 1'b1;
                        rsp_reg.live_entries  <= live_reg + 1'b1;
                        rsp_reg.slot_index    <= 8'(slot_reg);
                        rsp_reg.letter_out    <= job_reg.letter;
                        rsp_reg.vec_out0      <= job_reg.vec0;
                        rsp_reg.vec_out1      <= job_reg.vec1;
                        rsp_reg.vec_out2      <= job_reg.vec2;
                        st_reg                <= S_OUT;
                    end else if (job_reg.func != FN_INSERT && mk_rd_reg == MK_EMPTY) begin
                        rsp_reg.status <= ST_NOTFND;
                        st_reg         <= S_OUT;
                    end else if (job_reg.func != FN_INSERT && mk_rd_reg == MK_LIVE
                                 && key_rd_reg == job_reg.key) begin
                        rsp_reg.slot_index <= 8'(slot_reg);
                        rsp_reg.letter_out <= (job_reg.func == FN_UPD_CH)
                                              ? job_reg.letter : ltr_rd_reg;
                        rsp_reg.vec_out0 <= (job_reg.func == FN_UPD_VC)
                                            ? job_reg.vec0 : v0_rd_reg;
                        rsp_reg.vec_out1 <= (job_reg.func == FN_UPD_VC)
                                            ? job_reg.vec1 : v1_rd_reg;
                        rsp_reg.vec_out2 <= (job_reg.func == FN_UPD_VC)
                                            ? job_reg.vec2 : v2_rd_reg;
                        if (job_reg.func == FN_REMOVE && live_reg != 9'd0) begin
                            live_reg             <= live_reg - 1'b1;
                            rsp_reg.live_entries <= live_reg - 1'b1;
                        end
                        st_reg <= S_OUT;
                    end else if (step_reg == n_reg - 1'b1) begin
                        rsp_reg.status <= (job_reg.func == FN_INSERT)
                                          ? ST_FULL : ST_NOTFND;
                        st_reg         <= S_OUT;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                        if (slot_inc[NW-1:0] >= n_reg) slot_reg <= '0;
                        else slot_reg <= slot_inc[AW-1:0];
                        st_reg <= S_RD;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        st_reg <= (job_reg.func == FN_CLEAR) ? S_CLR : S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table with linear probing and tombstones.
//
//   channel  ports          payload
//   request  s_valid/ready  lpht_pkg::req_t
//   result   m_valid/ready  lpht_pkg::rsp_t
//   config   cfg_valid/rdy  table_size, 9 bits
//
// An item runs a bit serial modulo of the hash sum, then one memory read
// and check per probed slot. After reset and after a clear the mark memory
// is swept while the back takes no request. Results wait in an output
// register; the front register and a two entry queue keep taking requests
// meanwhile.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int KEY_BYTES = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lpht_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output lpht_pkg::rsp_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [8:0]     cfg_data
);
    import lpht_pkg::*;

    logic [8:0] size_reg;
    logic       fj_valid, fj_ready, bj_valid, bj_ready;
    job_t       fj, bj;

    // config register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) size_reg <= 9'd256;
        else if (cfg_valid) size_reg <= cfg_data;
    end

    lpht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_req(s_data),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    lpht_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
    );

    lpht_back u_back (
        .aclk(aclk), .aresetn(aresetn), .table_size(size_reg),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .out_valid(m_valid), .out_ready(m_ready), .out_rsp(m_data)
    );

    // result never reports more live entries than slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({23'd0, m_data.live_entries} <= SLOTS))
        else $error("live count above slots");

    // a failed result (not found, full or bad key) carries no slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |-> (m_data.slot_index == 8'd0))
        else $error("slot reported on failure");

    // a pending result holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped");

endmodule

// ===== sim/tb_linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Self-checking bench for the linear probing hash table. A behavioral copy of
// the table computes the expected result of every accepted request; a checker
// compares each result field by field. Covers directed corner cases, several
// table sizes, tombstone walks, full table, bad keys and a long random mix.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int WD_LIMIT = 20000;
    localparam int RX_HOLD  = 300;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [8:0] cfg_data;

    linear_probe_hash_table #(.KEY_BYTES(8)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // shadow copy of the table
    logic [1:0]  mark_sh [SLOTS];
    logic [63:0] key_sh [SLOTS];
    logic [7:0]  ltr_sh [SLOTS];
    logic [31:0] vec_sh [SLOTS][3];
    int unsigned live_sh;
    logic [8:0]  size_sh;

    rsp_t rsp_q[$];
    int   errors = 0;
    int   idle_cnt = 0;
    bit   rx_idle_en;
    bit   rx_hold_req = 1'b0;
    int   rx_hold_len = 0;
    bit   tx_idle_en;

    // key pool for repeated keys
    logic [63:0] key_pool[$];

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // expected result of one request, updates the shadow table
    function automatic rsp_t table_apply(req_t r);
        rsp_t o;
        int unsigned n;
        logic [63:0] k;
        logic [31:0] sum, m;
        logic [7:0] c;
        bit bad;
        int unsigned home, t;
        int hit;
        o = '0;
        n = (size_sh == 0) ? 1 : (size_sh > SLOTS ? SLOTS : size_sh);
        k = '0; sum = '0; bad = 0;
        for (int b = 0; b < 8; b++) begin
            c = r.key_text[8*b +: 8];
            if (c == 0) break;
            if (c > 127) bad = 1;
            k[8*b +: 8] = c;
            sum = sum + (32'(c) << (c >> 2));
        end
        if (!sum[31]) home = sum % n;
        else begin
            m = (32'd0 - sum) % n;
            home = (m == 0) ? 0 : n - m;
        end
        o.status = ST_OK;
        if (r.func == FN_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) mark_sh[i] = MK_EMPTY;
            live_sh = 0;
        end else if (r.func > FN_CLEAR) begin
            o.status = ST_NOTFND;
        end else if (bad) begin
            o.status = ST_BADKEY;
        end else if (r.func == FN_INSERT) begin
            o.status = ST_FULL;
            if (live_sh < n) begin
                for (int i = 0; i < n; i++) begin
                    t = (home + i) % n;
                    if (mark_sh[t] != MK_LIVE) begin
                        mark_sh[t] = MK_LIVE;
                        key_sh[t] = k;
                        ltr_sh[t] = r.letter_in;
                        vec_sh[t][0] = r.vec_in0;
                        vec_sh[t][1] = r.vec_in1;
                        vec_sh[t][2] = r.vec_in2;
                        live_sh++;
                        o.status = ST_OK;
                        o.slot_index = t[7:0];
                        o.letter_out = ltr_sh[t];
                        o.vec_out0 = vec_sh[t][0];
                        o.vec_out1 = vec_sh[t][1];
                        o.vec_out2 = vec_sh[t][2];
                        break;
                    end
                end
            end
        end else begin
            hit = -1;
            for (int i = 0; i < n; i++) begin
                t = (home + i) % n;
                if (mark_sh[t] == MK_EMPTY) break;
                if (mark_sh[t] == MK_LIVE && key_sh[t] == k) begin
                    hit = t;
                    break;
                end
            end
            if (hit < 0) o.status = ST_NOTFND;
            else begin
                t = hit;
                if (r.func == FN_UPD_CH) ltr_sh[t] = r.letter_in;
                if (r.func == FN_UPD_VC) begin
                    vec_sh[t][0] = r.vec_in0;
                    vec_sh[t][1] = r.vec_in1;
                    vec_sh[t][2] = r.vec_in2;
                end
                o.slot_index = t[7:0];
                o.letter_out = ltr_sh[t];
                o.vec_out0 = vec_sh[t][0];
                o.vec_out1 = vec_sh[t][1];
                o.vec_out2 = vec_sh[t][2];
                if (r.func == FN_REMOVE) begin
                    mark_sh[t] = MK_TOMB;
                    if (live_sh > 0) live_sh--;
                end
            end
        end
        o.live_entries = live_sh[8:0];
        return o;
    endfunction

    // send one request, predicting at acceptance
    task automatic send_req(req_t r);
        if (tx_idle_en && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        s_data  = r;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        rsp_q.push_back(table_apply(r));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // random ascii key, length 1..8, often from the pool
    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        int len;
        if (key_pool.size() > 0 && $urandom_range(0, 2) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        k = '0;
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 127));
        if ($urandom_range(0, 3) == 0) k = k | ({$urandom, $urandom} & ~((64'd1 << (8*len)) - 1)
            & {8{8'h7f}} & {{56{1'b1}}, 8'h00}) ;
        if (key_pool.size() < 40) key_pool.push_back(k);
        return k;
    endfunction

    function automatic req_t mk_req(logic [2:0] f, logic [63:0] k);
        req_t r;
        r.func = f;
        r.key_text = k;
        r.letter_in = 8'($urandom);
        r.vec_in0 = $urandom;
        r.vec_in1 = $urandom;
        r.vec_in2 = $urandom;
        return r;
    endfunction

    // drain expectations, then let the block settle
    task automatic wait_idle();
        while (rsp_q.size() > 0) @(negedge aclk);
        repeat (600) @(negedge aclk);
    endtask

    task automatic write_size(logic [8:0] v);
        wait_idle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        size_sh = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rsp_q.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                rsp_t e;
                e = rsp_q.pop_front();
                if (m_data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_data.status); errors++;
                end
                if (m_data.slot_index !== e.slot_index) begin
                    $error("slot_index exp %0d got %0d", e.slot_index, m_data.slot_index);
                    errors++;
                end
                if (m_data.letter_out !== e.letter_out) begin
                    $error("letter_out exp %h got %h", e.letter_out, m_data.letter_out);
                    errors++;
                end
                if (m_data.vec_out0 !== e.vec_out0) begin
                    $error("vec_out0 exp %h got %h", e.vec_out0, m_data.vec_out0); errors++;
                end
                if (m_data.vec_out1 !== e.vec_out1) begin
                    $error("vec_out1 exp %h got %h", e.vec_out1, m_data.vec_out1); errors++;
                end
                if (m_data.vec_out2 !== e.vec_out2) begin
                    $error("vec_out2 exp %h got %h", e.vec_out2, m_data.vec_out2); errors++;
                end
                if (m_data.live_entries !== e.live_entries) begin
                    $error("live_entries exp %0d got %0d", e.live_entries,
                        m_data.live_entries);
                    errors++;
                end
            end
        end
    end

    // receiver back pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b1;
        end else if (rx_hold_req && rx_hold_len < RX_HOLD) begin
            m_ready <= 1'b0;
            rx_hold_len <= rx_hold_len + 1;
        end else if (rx_idle_en && m_ready && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            idle_cnt <= $urandom_range(1, 6);
        end else if (!m_ready) begin
            if (idle_cnt <= 1) m_ready <= 1'b1;
            idle_cnt <= idle_cnt - 1;
        end
    end

    // watchdog on stalled progress
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || (rx_hold_req && rx_hold_len < RX_HOLD))
                quiet = 0;
            else quiet++;
            if (quiet >= WD_LIMIT) begin
                $display("tb_linear_probe_hash_table NOT OK");
                $finish;
            end
        end
    end

    // corners: bad keys, unknown func, key end rules, all funcs
    task automatic test_directed();
        logic [63:0] k;
        k = 64'h0000_0000_0000_4241;
        send_req(mk_req(FN_LOOKUP, k));
        send_req(mk_req(FN_INSERT, k));
        send_req(mk_req(FN_INSERT, k));
        send_req(mk_req(FN_LOOKUP, k | 64'hFFFF_0000_0000_0000 & 64'hFF00_0000_0000_0000
            | 64'h0000_0000_0000_0000));
        send_req(mk_req(FN_LOOKUP, 64'hFF00_0000_0000_4241));
        send_req(mk_req(FN_UPD_CH, k));
        send_req(mk_req(FN_UPD_VC, k));
        send_req(mk_req(FN_REMOVE, k));
        send_req(mk_req(FN_LOOKUP, k));
        send_req(mk_req(FN_REMOVE, k));
        send_req(mk_req(FN_INSERT, 64'hFFFF_FFFF_FFFF_FFFF));
        send_req(mk_req(FN_INSERT, 64'h0000_0000_0000_0080));
        send_req(mk_req(FN_INSERT, 64'h7F7F_7F7F_7F7F_7F7F));
        send_req(mk_req(FN_INSERT, 64'h7F7F_7F7F_7F7F_7F01));
        send_req(mk_req(FN_INSERT, 64'h0));
        send_req(mk_req(FN_LOOKUP, 64'h0));
        send_req(mk_req(FN_UNDEF6, 64'h41));
        send_req(mk_req(FN_UNDEF7, 64'hFFFF_FFFF_FFFF_FFFF));
        send_req(mk_req(FN_UPD_VC, 64'h80));
        send_req(mk_req(FN_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF));
        send_req(mk_req(FN_LOOKUP, 64'h7F7F_7F7F_7F7F_7F7F));
    endtask

    // small and large tables: fill, overflow, tombstone reuse, shrink and grow
    task automatic test_sizes();
        logic [8:0] sizes[6] = '{9'd1, 9'd0, 9'd3, 9'd511, 9'd7, 9'd256};
        foreach (sizes[i]) begin
            write_size(sizes[i]);
            for (int j = 0; j < 12; j++) begin
                logic [2:0] f;
                f = (j < 8) ? FN_INSERT : 3'($urandom_range(0, 4));
                send_req(mk_req(f, rand_key()));
            end
        end
        send_req(mk_req(FN_CLEAR, 64'h0));
    endtask

    // random mix, mostly valid keys, at one table size per call
    task automatic test_random(int count, logic [8:0] sz);
        write_size(sz);
        key_pool.delete();
        for (int i = 0; i < count; i++) begin
            logic [2:0] f;
            logic [63:0] k;
            int p;
            p = $urandom_range(0, 99);
            if (p < 35) f = FN_INSERT;
            else if (p < 55) f = FN_LOOKUP;
            else if (p < 70) f = FN_REMOVE;
            else if (p < 82) f = FN_UPD_CH;
            else if (p < 94) f = FN_UPD_VC;
            else if (p < 96) f = FN_CLEAR;
            else f = ($urandom_range(0, 1) == 0) ? FN_UNDEF6 : FN_UNDEF7;
            k = rand_key();
            if ($urandom_range(0, 19) == 0) k[8*$urandom_range(0, 7) + 7] = 1'b1;
            send_req(mk_req(f, k));
        end
    endtask

    // long receiver stall while requests keep coming
    task automatic test_backpressure();
        @(negedge aclk);
        rx_hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_req(mk_req(FN_INSERT, rand_key()));
    endtask

    initial begin
        rx_idle_en = 1; tx_idle_en = 1;
        aresetn = 0; s_valid = 0; s_data = '0; cfg_valid = 0; cfg_data = '0;
        for (int i = 0; i < SLOTS; i++) mark_sh[i] = MK_EMPTY;
        live_sh = 0; size_sh = 9'd256;
        repeat (7) @(negedge aclk);
        aresetn = 1;
        test_directed();
        test_sizes();
        test_random(300, 9'd13);
        test_backpressure();
        test_random(300, 9'd64);
        test_random(150, 9'd2);
        rx_idle_en = 0; tx_idle_en = 0;
        test_random(250, 9'd256);
        wait_idle();
        if (errors == 0) $display("tb_linear_probe_hash_table OK");
        else $display("tb_linear_probe_hash_table NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lpht_pkg.sv
rtl/lpht_front.sv
rtl/lpht_fifo.sv
rtl/lpht_back.sv
rtl/linear_probe_hash_table.sv
sim/tb_linear_probe_hash_table.sv
